// ----- hdl/alist_pkg.sv -----
// Package with the shared types and constants of the positional array list.
`timescale 1ns / 1ps

package alist_pkg;

  localparam int LIST_DEPTH_DEF = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [6:0] LIMIT_RESET = 7'd64;
  localparam logic signed [6:0] FOUND_NONE = -7'sd1;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_FIND   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic app;
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

// ----- hdl/alist_if.sv -----
// Handshake interfaces for the request, response and configuration channels.
`timescale 1ns / 1ps

interface alist_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] item_value;
  logic [6:0]         position;

  modport source (output valid, req_type, item_value, position, input ready);
  modport sink (input valid, req_type, item_value, position, output ready);
endinterface

interface alist_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [6:0] found_index;
  logic [6:0]        entry_total;

  modport source (output valid, status, found_index, entry_total, input ready);
  modport sink (input valid, status, found_index, entry_total, output ready);
endinterface

interface alist_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] list_limit;

  modport source (output valid, list_limit, input ready);
  modport sink (input valid, list_limit, output ready);
endinterface

// ----- hdl/alist_cell.sv -----
// One storage cell of the list, shifting with its neighbors and comparing its entry.
`timescale 1ns / 1ps

module alist_cell #(
  parameter int IDX        = 0,
  parameter int VALUE_BITS = 32,
  parameter int CMP_W      = 7
) (
  input  logic                  clk,
  input  alist_pkg::cell_cmd_t  cmd,
  input  logic [CMP_W-1:0]      pos,
  input  logic [CMP_W-1:0]      count,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [VALUE_BITS-1:0] prev,
  input  logic [VALUE_BITS-1:0] next,
  output logic [VALUE_BITS-1:0] data,
  output logic                  match
);
  import alist_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [VALUE_BITS-1:0] data_next;

  always_comb begin
    data_next = data;
    if (cmd.app && (MY_IDX == count)) begin
      data_next = value;
    end else if (cmd.ins) begin
      if (MY_IDX == pos) begin
        data_next = value;
      end else if (MY_IDX > pos) begin
        data_next = prev;
      end
    end else if (cmd.del && (MY_IDX >= pos)) begin
      data_next = next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign match = (data == value) && (MY_IDX < count);

endmodule

// ----- hdl/alist_prio.sv -----
// Priority encoder that picks the lowest set bit of the match vector.
`timescale 1ns / 1ps

module alist_prio #(
  parameter int WIDTH = 64,
  parameter int IDX_W = 6
) (
  input  logic [WIDTH-1:0] match,
  output logic             hit,
  output logic [IDX_W-1:0] idx
);
  import alist_pkg::*;

  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit = 1'b1;
        idx = IDX_W'(i);
      end
    end
  end

endmodule

// ----- hdl/array_list_insert_delete_find_top.sv -----
// Top level of the positional array list built as a row of register cells.
// A result is registered in the s1 stage and then in the response register after its request transfer.
// Throughput: one request per cycle while the response is not held; all cells shift or compare in the accept cycle.
// Back-pressure on the response holds the two-entry pipeline and then the request side.
// Reset clears the entry count and sets the limit to 64; entry contents are not cleared.
`timescale 1ns / 1ps

module array_list_insert_delete_find_top #(
  parameter int LIST_DEPTH = alist_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_BITS = alist_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  alist_in_if.sink    req,
  alist_out_if.source rsp,
  alist_cfg_if.sink   cfg
);
  import alist_pkg::*;

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [6:0]            list_limit;
  logic [CMP_W-1:0]      cnt_x;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      lim_x;
  logic [CMP_W-1:0]      eff_lim;
  logic                  full;
  logic                  accept;
  req_t                  kind;
  status_t               st;
  cell_cmd_t             cmd;
  logic signed [63:0]    val_ext;
  logic [VALUE_BITS-1:0] val;
  logic [VALUE_BITS-1:0] cell_data [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] match;

  logic                  s1_valid;
  logic [LIST_DEPTH-1:0] s1_match;
  status_t               s1_status;
  logic                  s1_find;
  logic [6:0]            s1_total;
  logic                  s1_adv;
  logic                  out_free;

  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;

  logic                  rsp_valid;
  status_t               rsp_status;
  logic signed [6:0]     rsp_found;
  logic [6:0]            rsp_total;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      list_limit <= cfg.list_limit;
    end
  end

  assign out_free  = !rsp_valid || rsp.ready;
  assign s1_adv    = s1_valid && out_free;
  assign req.ready = !s1_valid || s1_adv;
  assign accept    = req.valid && req.ready;

  assign val_ext = 64'(req.item_value);
  assign val     = val_ext[VALUE_BITS-1:0];
  assign kind    = req_t'(req.req_type);
  assign cnt_x   = CMP_W'(count);
  assign pos_x   = CMP_W'(req.position);
  assign lim_x   = CMP_W'(list_limit);
  assign eff_lim = (lim_x > CMP_W'(LIST_DEPTH)) ? CMP_W'(LIST_DEPTH) : lim_x;
  assign full    = cnt_x >= eff_lim;

  always_comb begin
    st         = ST_DONE;
    cmd        = '0;
    count_next = count;
    case (kind)
      REQ_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          cmd.app    = accept;
          count_next = CNT_W'(count + 1'b1);
        end
      end
      REQ_INSERT: begin
        if (pos_x > cnt_x) begin
          st = ST_BADPOS;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          cmd.ins    = accept;
          count_next = CNT_W'(count + 1'b1);
        end
      end
      REQ_DELETE: begin
        if (pos_x >= cnt_x) begin
          st = ST_BADPOS;
        end else begin
          cmd.del    = accept;
          count_next = CNT_W'(count - 1'b1);
        end
      end
      default: begin
        st = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    alist_cell #(
      .IDX        (i),
      .VALUE_BITS (VALUE_BITS),
      .CMP_W      (CMP_W)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .pos   (pos_x),
      .count (cnt_x),
      .value (val),
      .prev  (cell_data[(i > 0) ? i - 1 : i]),
      .next  (cell_data[(i < LIST_DEPTH - 1) ? i + 1 : i]),
      .data  (cell_data[i]),
      .match (match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_match  <= match;
      s1_status <= st;
      s1_find   <= (kind == REQ_FIND);
      s1_total  <= 7'(count_next);
    end
  end

  alist_prio #(
    .WIDTH (LIST_DEPTH),
    .IDX_W (IDX_W)
  ) u_prio (
    .match (s1_match),
    .hit   (hit),
    .idx   (hit_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp_total <= s1_total;
      if (s1_find) begin
        rsp_status <= hit ? ST_DONE : ST_NOTFOUND;
        rsp_found  <= hit ? $signed(7'(hit_idx)) : FOUND_NONE;
      end else begin
        rsp_status <= s1_status;
        rsp_found  <= FOUND_NONE;
      end
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.found_index = rsp_found;
  assign rsp.entry_total = rsp_total;

endmodule
